>>> src/mmt_pkg.sv
// Shared types and codes for the multiset membership table.
package mmt_pkg;

   localparam int ACTION_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int OCC_BITS    = 5;
   localparam int IN_BITS     = 32;

   localparam logic [ACTION_BITS-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_DEL   = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_QUERY = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ABSENT = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture request transaction
      logic match;    // compare value against all slots
      logic update;   // commit slot change and load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic out_free; // response register empty or draining this cycle
   } stat_type;

endpackage

>>> src/mmt_ctrl.sv
// Controller state machine for the multiset membership table.
module mmt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mmt_pkg::stat_type  stat,
   output mmt_pkg::cmd_type   cmd
);
   import mmt_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MATCH  = 2'd1;
   localparam logic [1:0] S_UPDATE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            // commit only once the response register can take the result
            if (stat.out_free) begin
               cmd.update = 1'b1;
               req_tready = 1'b1;
               if (req_tvalid) begin
                  cmd.load = 1'b1;
                  state_in = S_MATCH;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_match_follows_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.match)
      else $error("match step did not follow request load");

   a_update_after_match: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> $past(cmd.match) || $past(state_ff == S_UPDATE))
      else $error("update without a preceding match");

   a_update_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> stat.out_free)
      else $error("update while response register is full");

endmodule

>>> src/mmt_datapath.sv
// Slot table, parallel match, first-hit/first-free pick and response register.
module mmt_datapath #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mmt_pkg::cmd_type                 cmd,
   output mmt_pkg::stat_type                stat,
   input  logic [mmt_pkg::ACTION_BITS-1:0]  req_action,
   input  logic [mmt_pkg::IN_BITS-1:0]      req_value,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic                             rsp_found,
   output logic [mmt_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [mmt_pkg::OCC_BITS-1:0]     rsp_occupancy
);
   import mmt_pkg::*;

   logic [VALUE_BITS-1:0]  value_ext;
   logic [ACTION_BITS-1:0] act_ff;
   logic [VALUE_BITS-1:0]  val_ff;
   logic [VALUE_BITS-1:0]  slot_val_ff [CAPACITY];
   logic [CAPACITY-1:0]    slot_vld_ff;
   logic [CAPACITY-1:0]    slot_vld_in;
   logic [CAPACITY-1:0]    hit_vec_ff;
   logic [CAPACITY-1:0]    free_vec_ff;
   logic [CAPACITY-1:0]    hit_first;
   logic [CAPACITY-1:0]    free_first;
   logic [CAPACITY-1:0]    wr_sel;
   logic [OCC_BITS-1:0]    count_ff;
   logic [OCC_BITS-1:0]    count_in;
   logic                   hit_any;
   logic                   free_any;
   logic [STATUS_BITS-1:0] status_calc;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_found_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [OCC_BITS-1:0]    rsp_occ_ff;

   generate
      if (VALUE_BITS <= IN_BITS) begin : g_trunc
         assign value_ext = req_value[VALUE_BITS-1:0];
      end else begin : g_ext
         assign value_ext = {{(VALUE_BITS-IN_BITS){1'b0}}, req_value};
      end
   endgenerate

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         val_ff <= value_ext;
      end
   end

   // match step: one comparator per slot
   always_ff @(posedge clock) begin
      if (cmd.match) begin
         for (int i = 0; i < CAPACITY; i++) begin
            hit_vec_ff[i] <= slot_vld_ff[i] && (slot_val_ff[i] == val_ff);
         end
         free_vec_ff <= ~slot_vld_ff;
      end
   end

   // isolate lowest set bit
   assign hit_first  = hit_vec_ff & (~hit_vec_ff + CAPACITY'(1));
   assign free_first = free_vec_ff & (~free_vec_ff + CAPACITY'(1));
   assign hit_any    = |hit_vec_ff;
   assign free_any   = |free_vec_ff;

   always_comb begin
      slot_vld_in = slot_vld_ff;
      count_in    = count_ff;
      wr_sel      = '0;
      status_calc = ST_OK;
      case (act_ff)
         ACT_ADD: begin
            if (free_any) begin
               wr_sel      = free_first;
               slot_vld_in = slot_vld_ff | free_first;
               count_in    = count_ff + OCC_BITS'(1);
            end else begin
               status_calc = ST_FULL;
            end
         end
         ACT_DEL: begin
            if (hit_any) begin
               slot_vld_in = slot_vld_ff & ~hit_first;
               count_in    = count_ff - OCC_BITS'(1);
            end else begin
               status_calc = ST_ABSENT;
            end
         end
         default: begin
            // query and unused code: look only
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (wr_sel[i]) begin
               slot_val_ff[i] <= val_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= '0;
         count_ff    <= '0;
      end else if (cmd.update) begin
         slot_vld_ff <= slot_vld_in;
         count_ff    <= count_in;
      end
   end

   // response register
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in  = cmd.update ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_found_ff  <= hit_any;
         rsp_status_ff <= status_calc;
         rsp_occ_ff    <= count_in;
      end
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   a_count_tracks_valid: assert property (@(posedge clock) disable iff (reset)
      count_ff == OCC_BITS'($countones(slot_vld_ff)))
      else $error("stored count out of step with valid slots");

   a_update_sets_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> rsp_valid_ff)
      else $error("update did not present a response");

   a_one_slot_change: assert property (@(posedge clock) disable iff (reset)
      $onehot0(slot_vld_in ^ slot_vld_ff))
      else $error("more than one slot changes in an update");

endmodule

>>> src/multiset_membership_table.sv
// Top level of the multiset membership table: bounded bag of values in valid-tagged slots.
//
// Channel  Dir  Handshake              Payload
// req      in   req_tvalid/req_tready  tuser: action[1:0]; tdata: value[31:0]
// rsp      out  rsp_tvalid/rsp_tready  tdata: found[0], status[2:1], occupancy[7:3]
//
// Each item goes through a match step comparing the value against every slot
// in parallel, then an update step that picks the lowest hit or lowest free slot
// and loads the response register. The next request is accepted in the update step.
// Synchronous active-high reset clears all valid tags and the count; slot values
// are not cleared (an invalid slot is never compared as a hit).
// A stalled rsp holds the update step; one result waits while the next request
// is accepted and matched.
module multiset_membership_table #(
   parameter int CAPACITY   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request transaction
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [7:0]  req_tuser,   // [1:0] action, [7:2] zero
   // response transaction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] found, [2:1] status, [7:3] occupancy
);
   import mmt_pkg::*;

   cmd_type                cmd;
   stat_type               stat;
   logic                   rsp_found;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [OCC_BITS-1:0]    rsp_occupancy;

   // sequencing: idle / match / update
   mmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // slot table and response register
   mmt_datapath #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_tuser[ACTION_BITS-1:0]),
      .req_value     (req_tdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_found     (rsp_found),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   assign rsp_tdata = {rsp_occupancy, rsp_status, rsp_found};

endmodule
